@@ rtl/ttbl_pkg.sv @@
// Shared constants, command and status codes, and cell control type
// for the tracked identifier set table. No dependencies.
package ttbl_pkg;

   localparam int CAPACITY = 512;
   localparam int ID_BITS  = 22;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMD_W    = 2;
   localparam int STAT_W   = 3;

   // hit reduction: first level ORs groups of GRP_SIZE match bits
   localparam int GRP_SIZE = 32;
   localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_INVALID  = 3'd1;
   localparam logic [STAT_W-1:0] ST_EXISTS   = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic               cmp;         // capture compare result
      logic               add_wr;      // write ident at slot == count
      logic               wave_start;  // load shift token from match
      logic               wave_step;   // advance shift wave one cell
      logic [ID_BITS-1:0] ident;
      logic [CNT_W-1:0]   count;
   } cell_ctl_type;

endpackage

@@ rtl/ttbl_req_if.sv @@
// Request channel: valid/ready handshake carrying cmd and ident.
// Depends on ttbl_pkg.
interface ttbl_req_if import ttbl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [ID_BITS-1:0] ident;

   modport source (output valid, output cmd, output ident, input ready);
   modport sink   (input valid, input cmd, input ident, output ready);
endinterface

@@ rtl/ttbl_rsp_if.sv @@
// Response channel: valid/ready handshake carrying status, present and count.
// Depends on ttbl_pkg.
interface ttbl_rsp_if import ttbl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic              present;
   logic [CNT_W-1:0]  entry_count;

   modport source (output valid, output status, output present, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input present, input entry_count,
                   output ready);
endinterface

@@ rtl/ttbl_cell.sv @@
// One slot of the set: holds an identifier, a match flag and the shift token.
// Depends on ttbl_pkg.
module ttbl_cell import ttbl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cell_ctl_type       ctl,
   input  logic [IDX_W-1:0]   idx,
   input  logic [ID_BITS-1:0] next_id,
   input  logic               tok_prev,
   output logic [ID_BITS-1:0] id_out,
   output logic               match,
   output logic               tok
);

   logic [ID_BITS-1:0] slot_ff;
   logic               match_ff;
   logic               tok_ff, tok_in;
   logic               live;
   logic               at_tail;

   assign live    = CNT_W'(idx) < ctl.count;
   assign at_tail = CNT_W'(idx) == ctl.count;

   always_comb begin
      tok_in = tok_ff;
      if (ctl.wave_start) begin
         tok_in = match_ff;
      end else if (ctl.wave_step) begin
         tok_in = tok_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.cmp) begin
         match_ff <= live && (slot_ff == ctl.ident);
      end
      if (ctl.add_wr && at_tail) begin
         slot_ff <= ctl.ident;
      end else if (ctl.wave_step && tok_ff) begin
         slot_ff <= next_id;
      end
   end

   assign id_out = slot_ff;
   assign match  = match_ff;
   assign tok    = tok_ff;

endmodule

@@ rtl/ttbl_hitred.sv @@
// Two-level registered OR of the per-cell match flags.
// Depends on ttbl_pkg.
module ttbl_hitred import ttbl_pkg::*; (
   input  logic                clock,
   input  logic [CAPACITY-1:0] match,
   output logic                hit
);

   logic [NUM_GRP*GRP_SIZE-1:0] match_pad;
   logic [NUM_GRP-1:0]          grp_ff, grp_in;
   logic                        hit_ff;

   assign match_pad = (NUM_GRP*GRP_SIZE)'(match);

   always_comb begin
      for (int g = 0; g < NUM_GRP; g++) begin
         grp_in[g] = |match_pad[g*GRP_SIZE +: GRP_SIZE];
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
      hit_ff <= |grp_ff;
   end

   assign hit = hit_ff;

endmodule

@@ rtl/tracked_id_set_table_unit.sv @@
// Top level of the tracked identifier set table: sequencer, chain of slot
// cells and hit reduction. Depends on ttbl_pkg, ttbl_req_if, ttbl_rsp_if,
// ttbl_cell and ttbl_hitred.
//
// Usage:
//  - req_ch carries one request (cmd, ident); it is taken when valid and
//    ready are both high. ready is high only while the sequencer is idle.
//  - rsp_ch returns one response per request (status, present,
//    entry_count) from an output register.
//  - Lookup, add, clear and a remove that misses pass through compare
//    (every cell captures its match), the registered group OR, the
//    registered hit and the decide step, which loads the response into
//    the output register, and then return to idle.
//  - Remove of a held identifier also runs a shift wave after the
//    response is loaded: a shift token starts at the matching slot and walks
//    the cell chain one cell per cycle, each cell it passes pulling its
//    neighbor's identifier down, until it falls off the last cell.
//  - If the receiver stalls, a finished response waits in the output
//    register and the sequencer holds the next result until it is taken.
//  - Synchronous reset empties the set (count to zero) and drops any
//    pending response. Slot contents are not cleared; slots at or above
//    the count are never compared.
module tracked_id_set_table_unit import ttbl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   ttbl_req_if.sink       req_ch,
   ttbl_rsp_if.source     rsp_ch
);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CMP  = 3'd1;  // cells capture compare
   localparam logic [2:0] S_GRP  = 3'd2;  // group ORs registered
   localparam logic [2:0] S_HIT  = 3'd3;  // hit registered
   localparam logic [2:0] S_EXEC = 3'd4;  // decide, commit, respond
   localparam logic [2:0] S_WAVE = 3'd5;  // remove shift in progress

   logic [2:0]         state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff;
   logic [ID_BITS-1:0] ident_ff;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  status_ff;
   logic               present_ff;
   logic [CNT_W-1:0]   rcount_ff;

   logic               accept;
   logic               commit;
   logic               out_free;
   logic               hit;
   logic               add_go, rm_go;
   logic [STAT_W-1:0]  status_in;

   cell_ctl_type       ctl;
   logic [ID_BITS-1:0] id_vec [CAPACITY];
   logic [CAPACITY-1:0] match_vec;
   logic [CAPACITY-1:0] tok_vec;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign commit       = (state_ff == S_EXEC) && out_free;

   // command decode against the pre-command count and hit
   always_comb begin
      status_in = ST_OK;
      count_in  = count_ff;
      add_go    = 1'b0;
      rm_go     = 1'b0;
      unique case (cmd_ff)
         CMD_LOOKUP: begin
         end
         CMD_ADD: begin
            if (ident_ff == '0) begin
               status_in = ST_INVALID;
            end else if (hit) begin
               status_in = ST_EXISTS;
            end else if (count_ff >= CNT_W'(CAPACITY)) begin
               status_in = ST_FULL;
            end else begin
               add_go   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_REMOVE: begin
            if (!hit) begin
               status_in = ST_NOTFOUND;
            end else begin
               rm_go    = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_CMP;
         S_CMP:  state_in = S_GRP;
         S_GRP:  state_in = S_HIT;
         S_HIT:  state_in = S_EXEC;
         S_EXEC: begin
            if (commit) state_in = rm_go ? S_WAVE : S_IDLE;
         end
         S_WAVE: if (tok_vec[CAPACITY-1]) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_ch.cmd;
         ident_ff <= req_ch.ident;
      end
      if (commit) begin
         status_ff  <= status_in;
         present_ff <= hit;
         rcount_ff  <= count_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.present     = present_ff;
   assign rsp_ch.entry_count = rcount_ff;

   // broadcast to the cells
   assign ctl.cmp        = (state_ff == S_CMP);
   assign ctl.add_wr     = commit && add_go;
   assign ctl.wave_start = commit && rm_go;
   assign ctl.wave_step  = (state_ff == S_WAVE);
   assign ctl.ident      = ident_ff;
   assign ctl.count      = count_ff;

   // cell chain: each cell sees its upper neighbor's id and lower token
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ID_BITS-1:0] nxt;
      logic               tprev;
      if (i == CAPACITY - 1) begin : g_last
         assign nxt = id_vec[i];
      end else begin : g_mid
         assign nxt = id_vec[i+1];
      end
      if (i == 0) begin : g_first
         assign tprev = 1'b0;
      end else begin : g_rest
         assign tprev = tok_vec[i-1];
      end
      ttbl_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .idx      (IDX_W'(i)),
         .next_id  (nxt),
         .tok_prev (tprev),
         .id_out   (id_vec[i]),
         .match    (match_vec[i]),
         .tok      (tok_vec[i])
      );
   end

   ttbl_hitred u_hitred (
      .clock (clock),
      .match (match_vec),
      .hit   (hit)
   );

   // held identifiers are unique, so at most one cell matches
   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GRP) |-> $onehot0(match_vec))
      else $error("more than one slot matched");

   // at most one shift token in the chain
   a_tok_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("multiple shift tokens");

   // a committed remove starts exactly one token
   a_wave_start: assert property (@(posedge clock) disable iff (reset)
      (commit && rm_go) |=> $onehot(tok_vec))
      else $error("remove started without a token");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("count beyond capacity");

endmodule
